@@ rtl/altd_pkg.sv @@
package altd_pkg;

	localparam int BLOCK_MAX_DEF = 1024;
	localparam int SUMQ_W        = 48;
	localparam int CNTQ_W        = 17;
	localparam int CMDQ_DEPTH    = 2;
	localparam int DIV_STEPS     = 48;
	localparam int DCNT_W        = 6;

	localparam logic [7:0]  MULT_RST     = 8'd24;
	localparam logic [15:0] FLOOR_RST    = 16'd500;
	localparam logic [31:0] INTERVAL_RST = 32'd10000;

	localparam logic [1:0] REG_MULT     = 2'd0;
	localparam logic [1:0] REG_FLOOR    = 2'd1;
	localparam logic [1:0] REG_INTERVAL = 2'd2;

	localparam logic [1:0] KIND_BLOCK   = 2'd0;
	localparam logic [1:0] KIND_SUMMARY = 2'd1;
	localparam logic [1:0] KIND_EMPTY   = 2'd2;

	localparam logic FUNC_SAMPLE = 1'b0;
	localparam logic FUNC_FLUSH  = 1'b1;

	typedef struct packed {
		logic               func;
		logic signed [15:0] sample_value;
		logic               last_sample;
		logic [63:0]        block_time_ms;
		logic [31:0]        now_ms;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [15:0] block_rms;
		logic        is_transient;
		logic        window_due;
		logic [31:0] block_count;
		logic [15:0] rms_avg;
		logic [15:0] rms_max;
		logic [15:0] peak_level;
		logic [31:0] transient_count;
		logic [15:0] loudest_rms;
		logic [63:0] loudest_time_ms;
		logic [31:0] window_span;
	} out_item_t;

	typedef struct packed {
		logic              flush;
		logic [SUMQ_W-1:0] sum_sq;
		logic [CNTQ_W-1:0] samples;
		logic [15:0]       peak;
		logic [63:0]       stamp;
		logic [31:0]       now;
	} cmd_t;

	typedef struct packed {
		logic [7:0]  mult;
		logic [15:0] floor_lvl;
		logic [31:0] interval;
	} cfg_t;

endpackage

@@ rtl/audio_level_transient_detector_top.sv @@
// Sequence: a block result goes through command pickup, a 48-step divide, a 16-step root,
//   threshold and update once its closing sample is taken; a window summary skips the root
//   and threshold, and an empty-window reset goes straight from pickup to the result.
// Throughput: mid-block samples go in every cycle while the queue has room; the back
//   takes a new command only when idle, after the last one is done, and stalls while a result waits.
// Reset: arst_n clears all statistics and the result register and loads register defaults.
module audio_level_transient_detector_top
	import altd_pkg::*;
#(
	parameter int BLOCK_MAX = BLOCK_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  in_item_t    in_data,
	output logic        empty,
	input  logic        pop,
	output out_item_t   out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	cfg_t cfg_q;
	logic cfg_wr;
	logic q_full, q_empty, q_push, q_pop;
	cmd_t q_wdata, q_rdata;

	// Configuration registers; writes complete on the access phase.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mult      <= MULT_RST;
			cfg_q.floor_lvl <= FLOOR_RST;
			cfg_q.interval  <= INTERVAL_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_MULT:     cfg_q.mult      <= pwdata[7:0];
				REG_FLOOR:    cfg_q.floor_lvl <= pwdata[15:0];
				REG_INTERVAL: cfg_q.interval  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_MULT:     prdata = 32'(cfg_q.mult);
			REG_FLOOR:    prdata = 32'(cfg_q.floor_lvl);
			REG_INTERVAL: prdata = cfg_q.interval;
			default:      prdata = '0;
		endcase
	end

	// Front: accumulate each block, hand closed blocks and flushes to the queue.
	altd_front #(.BLOCK_MAX(BLOCK_MAX)) u_front (
		.clk, .arst_n, .push, .full, .in_data,
		.q_full, .q_push, .q_data(q_wdata)
	);

	// Decouple the front from the long divide and root sequence.
	altd_cmd_fifo #(.DEPTH(CMDQ_DEPTH)) u_fifo (
		.clk, .arst_n,
		.wr_en(q_push), .wr_data(q_wdata), .full(q_full),
		.rd_en(q_pop), .rd_data(q_rdata), .empty(q_empty)
	);

	// Back: divide, root, window statistics and the result register.
	altd_back u_back (
		.clk, .arst_n, .cfg(cfg_q),
		.q_empty, .q_data(q_rdata), .q_pop,
		.pop, .empty, .out_data
	);
endmodule

@@ rtl/altd_cmd_fifo.sv @@
module altd_cmd_fifo
	import altd_pkg::*;
#(
	parameter int DEPTH = CMDQ_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_data,
	output logic full,
	input  logic rd_en,
	output cmd_t rd_data,
	output logic empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (rd_en)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			cnt_q <= cnt_q + CNT_W'(wr_en) - CNT_W'(rd_en);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CNT_W'(DEPTH))
		else $error("command queue overfilled");
	assert property (@(posedge clk) disable iff (!arst_n) wr_en |-> !full)
		else $error("write into full command queue");
	assert property (@(posedge clk) disable iff (!arst_n) rd_en |-> !empty)
		else $error("read from empty command queue");
endmodule

@@ rtl/altd_front.sv @@
module altd_front
	import altd_pkg::*;
#(
	parameter int BLOCK_MAX = BLOCK_MAX_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  in_item_t in_data,
	input  logic     q_full,
	output logic     q_push,
	output cmd_t     q_data
);
	localparam int CNT_W = $clog2(BLOCK_MAX + 1);
	localparam int SUM_W = 31 + $clog2(BLOCK_MAX);

	logic [SUM_W-1:0] sum_q, sum_nx;
	logic [CNT_W-1:0] cnt_q, cnt_nx;
	logic [15:0]      peak_q, peak_nx, mag;
	logic [31:0]      sq;
	logic             take, close;

	assign full = q_full;
	assign take = push && !q_full;

	always_comb begin
		mag     = in_data.sample_value[15] ? 16'(-in_data.sample_value) : in_data.sample_value;
		sq      = mag * mag;
		sum_nx  = sum_q + SUM_W'(sq);
		cnt_nx  = cnt_q + 1'b1;
		peak_nx = (mag > peak_q) ? mag : peak_q;
		close   = in_data.last_sample || (cnt_nx >= CNT_W'(BLOCK_MAX));
	end

	assign q_push = take && ((in_data.func == FUNC_FLUSH) || close);

	always_comb begin
		q_data         = '0;
		q_data.flush   = (in_data.func == FUNC_FLUSH);
		q_data.sum_sq  = SUMQ_W'(sum_nx);
		q_data.samples = CNTQ_W'(cnt_nx);
		q_data.peak    = peak_nx;
		q_data.stamp   = in_data.block_time_ms;
		q_data.now     = in_data.now_ms;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			cnt_q  <= '0;
			peak_q <= '0;
		end else if (take && in_data.func == FUNC_SAMPLE) begin
			if (close) begin
				sum_q  <= '0;
				cnt_q  <= '0;
				peak_q <= '0;
			end else begin
				sum_q  <= sum_nx;
				cnt_q  <= cnt_nx;
				peak_q <= peak_nx;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q < CNT_W'(BLOCK_MAX))
		else $error("block sample count reached limit without closing");
	assert property (@(posedge clk) disable iff (!arst_n) (cnt_q == '0) |-> (sum_q == '0))
		else $error("sum of squares left over from closed block");
	assert property (@(posedge clk) disable iff (!arst_n)
		(take && in_data.func == FUNC_SAMPLE && close) |=> (cnt_q == '0))
		else $error("block did not restart after closing");
endmodule

@@ rtl/altd_back.sv @@
module altd_back
	import altd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      q_empty,
	input  cmd_t      q_data,
	output logic      q_pop,
	input  logic      pop,
	output logic      empty,
	output out_item_t out_data
);
	typedef enum logic [2:0] {S_IDLE, S_DIV, S_SQRT, S_THR, S_EMIT} state_t;

	state_t            state_q;
	cmd_t              cmd_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic [SUMQ_W-1:0] dvd_q, quo_q;
	logic [31:0]       dvs_q, rem_q;
	logic [31:0]       sv_q, sres_q, sbit_q;
	logic [15:0]       rms_q;
	logic [23:0]       prod_q;
	logic              out_valid_q;
	out_item_t         out_q;

	logic [31:0] blocks_q, trans_q, wstart_q;
	logic [47:0] rtotal_q;
	logic [15:0] rhigh_q, wpeak_q, amb_q, loud_q;
	logic [63:0] lstamp_q;

	logic [32:0] rem_sh, rem_sub;
	logic        q_bit;
	logic [31:0] sum_rb;
	logic        out_free, emit;

	logic [31:0] blocks_nx, wms;
	logic [20:0] thr_raw;
	logic [20:0] thr;
	logic        is_trans;
	logic signed [16:0] diff;
	logic [16:0] dmag;
	logic [15:0] amb_nx;
	out_item_t   res;

	assign rem_sh  = {rem_q, dvd_q[SUMQ_W-1]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};
	assign q_bit   = !rem_sub[32];
	assign sum_rb  = sres_q + sbit_q;

	assign out_free = !out_valid_q || pop;
	assign emit     = (state_q == S_EMIT) && out_free;
	assign q_pop    = (state_q == S_IDLE) && !q_empty;
	assign empty    = !out_valid_q;
	assign out_data = out_q;

	always_comb begin
		blocks_nx = blocks_q + 1'b1;
		wms       = cmd_q.now - wstart_q;
		thr_raw   = 21'(prod_q >> 3);
		thr       = (thr_raw < 21'(cfg.floor_lvl)) ? 21'(cfg.floor_lvl) : thr_raw;
		is_trans  = (blocks_nx > 32'd4) && (21'(rms_q) > thr);
		diff      = $signed({1'b0, rms_q}) - $signed({1'b0, amb_q});
		dmag      = diff[16] ? 17'(-diff) : 17'(diff);
		amb_nx    = diff[16] ? amb_q - 16'(dmag >> 3) : amb_q + 16'(dmag >> 3);

		res = '0;
		if (!cmd_q.flush) begin
			res.result_kind  = KIND_BLOCK;
			res.block_rms    = rms_q;
			res.is_transient = is_trans;
			res.window_due   = (blocks_nx != '0) && (wms >= cfg.interval);
		end else if (blocks_q == '0) begin
			res.result_kind = KIND_EMPTY;
		end else begin
			res.result_kind     = KIND_SUMMARY;
			res.window_due      = (wms >= cfg.interval);
			res.block_count     = blocks_q;
			res.rms_avg         = quo_q[15:0];
			res.rms_max         = rhigh_q;
			res.peak_level      = wpeak_q;
			res.transient_count = trans_q;
			res.loudest_rms     = loud_q;
			res.loudest_time_ms = lstamp_q;
			res.window_span     = wms;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) cmd_q <= q_data;
		case (state_q)
			S_IDLE: begin
				dvd_q <= q_data.flush ? rtotal_q : q_data.sum_sq;
				dvs_q <= q_data.flush ? blocks_q : 32'(q_data.samples);
				rem_q <= '0;
				quo_q <= '0;
			end
			S_DIV: begin
				rem_q  <= q_bit ? rem_sub[31:0] : rem_sh[31:0];
				quo_q  <= {quo_q[SUMQ_W-2:0], q_bit};
				dvd_q  <= {dvd_q[SUMQ_W-2:0], 1'b0};
				sv_q   <= {quo_q[30:0], q_bit};
				sres_q <= '0;
				sbit_q <= 32'h4000_0000;
			end
			S_SQRT: begin
				if (sv_q >= sum_rb) begin
					sv_q   <= sv_q - sum_rb;
					sres_q <= (sres_q >> 1) + sbit_q;
				end else begin
					sres_q <= sres_q >> 1;
				end
				sbit_q <= sbit_q >> 2;
				rms_q  <= sres_q[15:0];
			end
			S_THR: begin
				rms_q  <= sres_q[15:0];
				prod_q <= amb_q * cfg.mult;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			dcnt_q      <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			blocks_q    <= '0;
			trans_q     <= '0;
			wstart_q    <= '0;
			rtotal_q    <= '0;
			rhigh_q     <= '0;
			wpeak_q     <= '0;
			amb_q       <= '0;
			loud_q      <= '0;
			lstamp_q    <= '0;
		end else begin
			if (emit) out_q <= res;
			if (emit) out_valid_q <= 1'b1;
			else if (pop) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					dcnt_q <= DCNT_W'(DIV_STEPS - 1);
					if (!q_empty)
						state_q <= (q_data.flush && blocks_q == '0) ? S_EMIT : S_DIV;
				end
				S_DIV: begin
					dcnt_q <= dcnt_q - 1'b1;
					if (dcnt_q == '0) state_q <= cmd_q.flush ? S_EMIT : S_SQRT;
				end
				S_SQRT: begin
					if (sbit_q == 32'd1) state_q <= S_THR;
				end
				S_THR: state_q <= S_EMIT;
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
						if (cmd_q.flush) begin
							blocks_q <= '0;
							trans_q  <= '0;
							rtotal_q <= '0;
							rhigh_q  <= '0;
							wpeak_q  <= '0;
							amb_q    <= '0;
							loud_q   <= '0;
							lstamp_q <= '0;
							wstart_q <= cmd_q.now;
						end else begin
							blocks_q <= blocks_nx;
							rtotal_q <= rtotal_q + 48'(rms_q);
							if (rms_q > rhigh_q) rhigh_q <= rms_q;
							if (cmd_q.peak > wpeak_q) wpeak_q <= cmd_q.peak;
							if (is_trans) begin
								trans_q <= trans_q + 1'b1;
								if (rms_q > loud_q) begin
									loud_q   <= rms_q;
									lstamp_q <= cmd_q.stamp;
								end
							end
							amb_q <= amb_nx;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) emit |-> (!out_valid_q || pop))
		else $error("result register overwritten");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.result_kind != 2'd3))
		else $error("illegal result kind");
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |=> (state_q != S_IDLE))
		else $error("command taken but sequencer idle");
endmodule
